[rtl/fipd_pkg.sv]
// ============================================================================
// Fall impact peak detector package
// Shared types, field widths and reset constants for the detector and its
// serial arithmetic units.
// ============================================================================
package fipd_pkg;

    // Field widths
    localparam int ACC_W   = 16;
    localparam int SUM_W   = 32;
    localparam int PEAK_W  = 16;
    localparam int DIGIT_W = 4;
    localparam int TICK_W  = 16;
    localparam int CFG_W   = 32;

    // Register reset values
    localparam logic [TICK_W-1:0] BLINK_RESET     = 16'd500;
    localparam logic [TICK_W-1:0] DISPLAY_RESET   = 16'd10000;
    localparam logic [SUM_W-1:0]  THRESHOLD_RESET = 32'd5207;

    // Input item kinds, carried on s_tuser
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_FALL   = 2'd2,
        CMD_BUTTON = 2'd3
    } cmd_t;

    // Operating modes
    typedef enum logic [1:0] {
        MODE_REST = 2'd0,
        MODE_FALL = 2'd1,
        MODE_DISP = 2'd2
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_BLINK     = 2'd0,
        CFG_DISPLAY   = 2'd1,
        CFG_THRESHOLD = 2'd2
    } cfg_idx_t;

    // One result transaction, last field in the lowest bits
    typedef struct packed {
        logic [DIGIT_W-1:0] hundredths_digit;
        logic [DIGIT_W-1:0] tenths_digit;
        logic [DIGIT_W-1:0] units_digit;
        logic [PEAK_W-1:0]  peak_centi_g;
        logic               impact_now;
        logic               red_led;
        mode_t              mode;
    } result_t;

endpackage

[rtl/fall_impact_peak_detector_unit.sv]
// ============================================================================
// Fall impact peak detector
// Tracks rest, free-fall and display modes from ticks, acceleration samples,
// free-fall events and button presses, and reports the impact peak.
// ============================================================================
// Usage:
//   The slave channel takes one command per transaction: s_tuser is the kind
//   (tick, sample, free-fall event, button) and s_tdata holds the three axis
//   samples in hundredths of g. Every accepted transaction yields exactly one
//   result transaction on the master channel.
//   Ticks, events, buttons and samples outside free fall go from acceptance
//   straight to the final step, which loads the result once the output
//   register is free; the sequencer then returns to idle to accept the next
//   transaction. A sample in free fall builds its sum of squares in a shared
//   shift-add accumulator, one multiplier bit per cycle; then the evaluate,
//   check and final steps compare, check and load the result. A sample that
//   detects an impact also passes through the bit-serial square root and the
//   decimal conversion between the check and the final step.
//   The block works on one transaction at a time; s_tready is high whenever
//   the sequencer is idle, even while a finished result waits in the output
//   register. When the receiver stalls, the next result waits until the output
//   register is free and the sequencer holds off further input. Configuration
//   writes take effect at once; the user must make them while idle, as the block
//   does not enforce it. After reset the block is at rest with the LED off, peak
//   zero, default tick counts and a zero previous sum; no clearing pass is needed.
// ============================================================================
module fall_impact_peak_detector_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Slave channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,   // acc_x, acc_y, acc_z
    input  logic [1:0]                 s_tuser,   // cmd
    // Master channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // mode, red_led, impact_now,
                                                  // peak_centi_g, units_digit,
                                                  // tenths_digit, hundredths_digit
    // Configuration write port
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [fipd_pkg::CFG_W-1:0] cfg_data
);
    import fipd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_EVAL,
        ST_CHECK,
        ST_SQRT,
        ST_BCD,
        ST_POST
    } state_t;

    state_t              state_reg;
    mode_t               mode_reg;
    logic                pending_reg;
    logic                led_reg;
    logic                impact_reg;
    logic [TICK_W-1:0]   blink_ticks_reg;
    logic [TICK_W-1:0]   display_ticks_reg;
    logic [SUM_W-1:0]    threshold_reg;
    logic [TICK_W-1:0]   blink_count_reg;
    logic [TICK_W-1:0]   display_count_reg;
    logic [SUM_W-1:0]    prev_sum_reg;
    logic [SUM_W-1:0]    peak_sum_reg;
    logic [SUM_W-1:0]    acc_reg;
    logic [SUM_W-1:0]    diff_reg;
    logic [ACC_W-1:0]    mag_x_reg, mag_y_reg, mag_z_reg;
    logic [ACC_W-1:0]    shf_x_reg, shf_y_reg, shf_z_reg;
    logic [3:0]          bit_cnt_reg;
    logic [PEAK_W-1:0]   peak_hold_reg;
    logic [DIGIT_W-1:0]  units_reg, tenths_reg, hundredths_reg;
    logic                m_valid_reg;
    result_t             m_data_reg;

    logic [SUM_W-1:0]    acc_next;
    logic [TICK_W-1:0]   blink_dec, display_dec;
    logic [ACC_W-1:0]    ax, ay, az;
    logic                impact_hit;
    logic                out_free;
    logic                sqrt_start, sqrt_done;
    logic [PEAK_W-1:0]   sqrt_root;
    logic                bcd_done;
    logic [DIGIT_W-1:0]  bcd_units, bcd_tenths, bcd_hundredths;
    mode_t               mode_after;

    // Axis magnitudes; the most negative sample maps to 32768, which still fits.
    assign ax = s_tdata[15] ? (~s_tdata[15:0] + 16'd1)  : s_tdata[15:0];
    assign ay = s_tdata[31] ? (~s_tdata[31:16] + 16'd1) : s_tdata[31:16];
    assign az = s_tdata[47] ? (~s_tdata[47:32] + 16'd1) : s_tdata[47:32];

    // Shared shift-add step: one multiplier bit of each axis per cycle, MSB first.
    assign acc_next = {acc_reg[SUM_W-2:0], 1'b0}
                    + (shf_x_reg[ACC_W-1] ? {16'd0, mag_x_reg} : '0)
                    + (shf_y_reg[ACC_W-1] ? {16'd0, mag_y_reg} : '0)
                    + (shf_z_reg[ACC_W-1] ? {16'd0, mag_z_reg} : '0);

    // Tick counters count down and hold at zero.
    assign blink_dec   = (blink_count_reg == '0)   ? '0 : blink_count_reg - 16'd1;
    assign display_dec = (display_count_reg == '0) ? '0 : display_count_reg - 16'd1;

    assign impact_hit = (diff_reg >= threshold_reg) && (prev_sum_reg != '0);
    assign sqrt_start = (state_reg == ST_CHECK) && impact_hit;
    assign out_free   = !m_valid_reg || m_tready;

    // A latched free-fall event enters free fall as soon as the block rests.
    assign mode_after = (mode_reg == MODE_REST && pending_reg) ? MODE_FALL : mode_reg;

    fipd_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (peak_sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    fipd_bcd u_bcd (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (sqrt_done),
        .value      (sqrt_root),
        .done       (bcd_done),
        .units      (bcd_units),
        .tenths     (bcd_tenths),
        .hundredths (bcd_hundredths)
    );

    // Sequencer, detector state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            mode_reg          <= MODE_REST;
            pending_reg       <= 1'b0;
            led_reg           <= 1'b0;
            impact_reg        <= 1'b0;
            blink_ticks_reg   <= BLINK_RESET;
            display_ticks_reg <= DISPLAY_RESET;
            threshold_reg     <= THRESHOLD_RESET;
            blink_count_reg   <= BLINK_RESET;
            display_count_reg <= DISPLAY_RESET;
            prev_sum_reg      <= '0;
            peak_sum_reg      <= '0;
            peak_hold_reg     <= '0;
            units_reg         <= '0;
            tenths_reg        <= '0;
            hundredths_reg    <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            // Configuration writes; index three has no register.
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BLINK:     blink_ticks_reg   <= cfg_data[TICK_W-1:0];
                    CFG_DISPLAY:   display_ticks_reg <= cfg_data[TICK_W-1:0];
                    CFG_THRESHOLD: threshold_reg     <= cfg_data;
                    default: ;
                endcase
            end

            // The output register fills from the final step and empties when taken.
            if (state_reg == ST_POST && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        impact_reg <= 1'b0;
                        // Only a sample in free fall needs the arithmetic steps.
                        state_reg  <= (s_tuser == CMD_SAMPLE && mode_reg == MODE_FALL)
                                      ? ST_SQUARE : ST_POST;
                        unique case (s_tuser)
                            CMD_TICK: begin
                                display_count_reg <= display_dec;
                                if (mode_reg == MODE_FALL && blink_dec == '0) begin
                                    led_reg         <= ~led_reg;
                                    blink_count_reg <= blink_ticks_reg;
                                end else begin
                                    blink_count_reg <= blink_dec;
                                    if (mode_reg == MODE_DISP && display_dec == '0) begin
                                        mode_reg <= MODE_REST;
                                    end
                                end
                            end
                            CMD_SAMPLE: begin
                                if (mode_reg == MODE_FALL) begin
                                    mag_x_reg   <= ax;
                                    mag_y_reg   <= ay;
                                    mag_z_reg   <= az;
                                    shf_x_reg   <= ax;
                                    shf_y_reg   <= ay;
                                    shf_z_reg   <= az;
                                    acc_reg     <= '0;
                                    bit_cnt_reg <= 4'd15;
                                end
                            end
                            CMD_FALL: begin
                                pending_reg <= 1'b1;
                            end
                            CMD_BUTTON: begin
                                if (mode_reg == MODE_DISP) begin
                                    mode_reg <= MODE_REST;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SQUARE: begin
                    acc_reg     <= acc_next;
                    shf_x_reg   <= {shf_x_reg[ACC_W-2:0], 1'b0};
                    shf_y_reg   <= {shf_y_reg[ACC_W-2:0], 1'b0};
                    shf_z_reg   <= {shf_z_reg[ACC_W-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - 4'd1;
                    if (bit_cnt_reg == 4'd0) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    // Distance from the previous sum, and the running peak.
                    diff_reg <= (acc_reg >= prev_sum_reg) ? acc_reg - prev_sum_reg
                                                          : prev_sum_reg - acc_reg;
                    if (acc_reg > peak_sum_reg) begin
                        peak_sum_reg <= acc_reg;
                    end
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    prev_sum_reg <= acc_reg;
                    if (impact_hit) begin
                        mode_reg          <= MODE_DISP;
                        display_count_reg <= display_ticks_reg;
                        led_reg           <= 1'b0;
                        impact_reg        <= 1'b1;
                        state_reg         <= ST_SQRT;
                    end else begin
                        state_reg <= ST_POST;
                    end
                end
                ST_SQRT: begin
                    if (sqrt_done) begin
                        peak_hold_reg <= sqrt_root;
                        state_reg     <= ST_BCD;
                    end
                end
                ST_BCD: begin
                    if (bcd_done) begin
                        units_reg      <= bcd_units;
                        tenths_reg     <= bcd_tenths;
                        hundredths_reg <= bcd_hundredths;
                        state_reg      <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (out_free) begin
                        if (mode_reg == MODE_REST && pending_reg) begin
                            pending_reg     <= 1'b0;
                            prev_sum_reg    <= '0;
                            peak_sum_reg    <= '0;
                            blink_count_reg <= blink_ticks_reg;
                        end
                        mode_reg                    <= mode_after;
                        m_data_reg.mode             <= mode_after;
                        m_data_reg.red_led          <= led_reg;
                        m_data_reg.impact_now       <= impact_reg;
                        m_data_reg.peak_centi_g     <= peak_hold_reg;
                        m_data_reg.units_digit      <= units_reg;
                        m_data_reg.tenths_digit     <= tenths_reg;
                        m_data_reg.hundredths_digit <= hundredths_reg;
                        state_reg                   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // An impact result always reports the display mode.
    a_impact_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> (m_tdata[1:0] == MODE_DISP))
        else $error("impact result without display mode");

    // The square root only runs after an impact switched to display mode.
    a_sqrt_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> (mode_reg == MODE_DISP))
        else $error("square root running outside display mode");

    // A new result appears only from the final sequencer step.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_POST))
        else $error("result loaded outside the final step");

endmodule

[rtl/fipd_isqrt.sv]
// ============================================================================
// Serial rounded square root
// Restoring square root, one result bit per cycle, followed by a rounding
// step that rounds half up. A done pulse marks a valid root.
// ============================================================================
module fipd_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [fipd_pkg::SUM_W-1:0]  radicand,
    output logic                        done,
    output logic [fipd_pkg::PEAK_W-1:0] root
);
    import fipd_pkg::*;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_ROUND
    } sq_state_t;

    sq_state_t           state_reg;
    logic [SUM_W-1:0]    rad_reg;
    logic [19:0]         rem_reg;
    logic [PEAK_W-1:0]   root_reg;
    logic [3:0]          cnt_reg;
    logic                done_reg;
    logic [PEAK_W-1:0]   result_reg;

    logic [19:0]         rem_shift;
    logic [19:0]         trial;
    logic                fits;

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_shift = {rem_reg[17:0], rad_reg[SUM_W-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SQ_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                SQ_IDLE: begin
                    if (start) begin
                        rad_reg   <= radicand;
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= 4'd15;
                        state_reg <= SQ_RUN;
                    end
                end
                SQ_RUN: begin
                    rad_reg <= {rad_reg[SUM_W-3:0], 2'b00};
                    if (fits) begin
                        rem_reg  <= rem_shift - trial;
                        root_reg <= {root_reg[PEAK_W-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_shift;
                        root_reg <= {root_reg[PEAK_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0) begin
                        state_reg <= SQ_ROUND;
                    end
                end
                SQ_ROUND: begin
                    // The remainder is s - r*r; round up when it exceeds r.
                    if (rem_reg > {4'b0000, root_reg}) begin
                        result_reg <= root_reg + 16'd1;
                    end else begin
                        result_reg <= root_reg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= SQ_IDLE;
                end
                default: begin
                    state_reg <= SQ_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign root = result_reg;

endmodule

[rtl/fipd_bcd.sv]
// ============================================================================
// Serial binary to decimal converter
// Shift-and-add-three conversion, one binary bit per cycle, keeping only the
// three lowest decimal digits of the value.
// ============================================================================
module fipd_bcd (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [fipd_pkg::PEAK_W-1:0]  value,
    output logic                         done,
    output logic [fipd_pkg::DIGIT_W-1:0] units,
    output logic [fipd_pkg::DIGIT_W-1:0] tenths,
    output logic [fipd_pkg::DIGIT_W-1:0] hundredths
);
    import fipd_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [PEAK_W-1:0]   bin_reg;
    logic [11:0]         bcd_reg;
    logic [3:0]          cnt_reg;
    logic [11:0]         bcd_adj;

    function automatic logic [DIGIT_W-1:0] dabble(input logic [DIGIT_W-1:0] d);
        dabble = (d >= 4'd5) ? d + 4'd3 : d;
    endfunction

    // Correct each digit before it doubles. Higher digits never feed lower
    // ones, so dropping the digits above hundreds keeps the low three exact.
    assign bcd_adj = {dabble(bcd_reg[11:8]), dabble(bcd_reg[7:4]), dabble(bcd_reg[3:0])};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (start) begin
                    bin_reg  <= value;
                    bcd_reg  <= '0;
                    cnt_reg  <= 4'd15;
                    busy_reg <= 1'b1;
                end
            end else begin
                bcd_reg <= {bcd_adj[10:0], bin_reg[PEAK_W-1]};
                bin_reg <= {bin_reg[PEAK_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done       = done_reg;
    assign hundredths = bcd_reg[3:0];
    assign tenths     = bcd_reg[7:4];
    assign units      = bcd_reg[11:8];

endmodule

[bench/fall_impact_peak_detector_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fall impact peak detector unit test
// Drives ticks, acceleration samples, free-fall events and button presses into
// the detector and checks every result transaction against a cycle-free
// prediction of the mode, LED, impact flag, latched peak and its digits.
// ----------------------------------------------------------------------------
module fall_impact_peak_detector_unit_test;
    import fipd_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 60;
    localparam int SEGMENT_ITEMS  = 225;
    localparam int NUM_SEGMENTS   = 6;
    localparam int MAX_REPORTS    = 10;
    localparam logic [SUM_W-1:0] THRESHOLD_MAX = 32'd3221225472;

    // Prediction of the detector: its own copy of the registers and state, and
    // the queue of result transactions still to arrive.
    class impact_scoreboard;
        logic [TICK_W-1:0] blink_ticks;
        logic [TICK_W-1:0] display_ticks;
        logic [SUM_W-1:0]  threshold;
        mode_t             cur_mode;
        logic [SUM_W-1:0]  prev_sum;
        logic [SUM_W-1:0]  peak_sum;
        logic [TICK_W-1:0] blink_count;
        logic [TICK_W-1:0] display_count;
        bit                fall_pending;
        bit                led;
        logic [PEAK_W-1:0] peak_hold;
        result_t           expected_q[$];
        int                errors;

        function new();
            blink_ticks   = BLINK_RESET;
            display_ticks = DISPLAY_RESET;
            threshold     = THRESHOLD_RESET;
            cur_mode      = MODE_REST;
            prev_sum      = '0;
            peak_sum      = '0;
            blink_count   = BLINK_RESET;
            display_count = DISPLAY_RESET;
            fall_pending  = 1'b0;
            led           = 1'b0;
            peak_hold     = '0;
            errors        = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_BLINK:     blink_ticks = value[TICK_W-1:0];
                CFG_DISPLAY:   display_ticks = value[TICK_W-1:0];
                CFG_THRESHOLD: threshold = value;
                default: ;
            endcase
        endfunction

        // Square of one centi-g axis; the most negative value squares to 2^30.
        function logic [SUM_W-1:0] axis_energy(logic [ACC_W-1:0] raw);
            logic [ACC_W-1:0] mag;
            mag = raw[ACC_W-1] ? (~raw + 16'd1) : raw;
            return {16'd0, mag} * {16'd0, mag};
        endfunction

        // Advances the prediction by one accepted transaction.
        function void note_input(cmd_t cmd, logic [47:0] data);
            logic [SUM_W-1:0] sum;
            logic [SUM_W-1:0] diff;
            logic [63:0]      root;
            logic [63:0]      trial;
            bit               impact;
            result_t          want;
            impact = 1'b0;
            case (cmd)
                CMD_TICK: begin
                    // Both counters run down in every mode and stop at zero.
                    if (blink_count != 0) blink_count = blink_count - 16'd1;
                    if (display_count != 0) display_count = display_count - 16'd1;
                    if (cur_mode == MODE_FALL && blink_count == 0) begin
                        led         = ~led;
                        blink_count = blink_ticks;
                    end else if (cur_mode == MODE_DISP && display_count == 0) begin
                        cur_mode = MODE_REST;
                    end
                end
                CMD_SAMPLE: begin
                    if (cur_mode == MODE_FALL) begin
                        sum = axis_energy(data[15:0]) + axis_energy(data[31:16]) +
                              axis_energy(data[47:32]);
                        diff = (sum >= prev_sum) ? sum - prev_sum : prev_sum - sum;
                        if (sum > peak_sum) peak_sum = sum;
                        if (diff >= threshold && prev_sum != 0) begin
                            cur_mode      = MODE_DISP;
                            display_count = display_ticks;
                            // Floor square root bit by bit, then round half up.
                            root = 64'd0;
                            for (int b = 15; b >= 0; b--) begin
                                trial = root | (64'd1 << b);
                                if (trial * trial <= {32'd0, peak_sum}) root = trial;
                            end
                            if ({32'd0, peak_sum} - root * root > root) root = root + 64'd1;
                            peak_hold = root[PEAK_W-1:0];
                            led       = 1'b0;
                            impact    = 1'b1;
                        end
                        prev_sum = sum;
                    end
                end
                CMD_FALL: fall_pending = 1'b1;
                default: begin
                    if (cur_mode == MODE_DISP) cur_mode = MODE_REST;
                end
            endcase

            // A latched free-fall event takes effect as soon as the block rests.
            if (cur_mode == MODE_REST && fall_pending) begin
                fall_pending = 1'b0;
                prev_sum     = '0;
                peak_sum     = '0;
                blink_count  = blink_ticks;
                cur_mode     = MODE_FALL;
            end

            want.mode             = cur_mode;
            want.red_led          = led;
            want.impact_now       = impact;
            want.peak_centi_g     = peak_hold;
            want.units_digit      = DIGIT_W'((peak_hold / 100) % 10);
            want.tenths_digit     = DIGIT_W'((peak_hold / 10) % 10);
            want.hundredths_digit = DIGIT_W'(peak_hold % 10);
            expected_q.push_back(want);
        endfunction

        function void check_result(logic [31:0] raw);
            result_t got;
            result_t want;
            got = result_t'(raw);
            if (expected_q.size() == 0) begin
                report($sformatf("result %h arrived with no transaction pending", raw));
                return;
            end
            want = expected_q.pop_front();
            if (got.mode !== want.mode || got.red_led !== want.red_led ||
                got.impact_now !== want.impact_now ||
                got.peak_centi_g !== want.peak_centi_g ||
                got.units_digit !== want.units_digit ||
                got.tenths_digit !== want.tenths_digit ||
                got.hundredths_digit !== want.hundredths_digit) begin
                report($sformatf({"mode %0d/%0d led %0d/%0d impact %0d/%0d ",
                                  "peak %0d/%0d digits %0d.%0d%0d/%0d.%0d%0d ",
                                  "(expected/actual)"},
                                 want.mode, got.mode, want.red_led, got.red_led,
                                 want.impact_now, got.impact_now,
                                 want.peak_centi_g, got.peak_centi_g,
                                 want.units_digit, want.tenths_digit,
                                 want.hundredths_digit, got.units_digit,
                                 got.tenths_digit, got.hundredths_digit));
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata   = '0;    // acc_x, acc_y, acc_z
    logic [1:0]            s_tuser   = CMD_TICK; // cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;           // mode, red_led, impact_now,
                                              // peak_centi_g, units_digit,
                                              // tenths_digit, hundredths_digit
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = CFG_BLINK;
    logic [CFG_W-1:0]      cfg_data  = '0;

    impact_scoreboard sb = new();
    int          send_idle_pct = 9;
    int          recv_idle_pct = 54;
    int unsigned quiet_cycles  = 0;

    fall_impact_peak_detector_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Receiver: random back-pressure, results checked as they are accepted.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("fall_impact_peak_detector_unit_test: done, errors");
                $finish;
            end
        end
    end

    function automatic logic [47:0] axes(int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    // Presents one command after a random gap and waits for its acceptance.
    // Entered and left just after a falling edge.
    task automatic send(cmd_t cmd, logic [47:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_input(cmd, data);
        @(negedge aclk);
    endtask

    // Stops the sender until every expected result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_register(idx, value);
        @(negedge aclk);
    endtask

    task automatic configure(logic [CFG_W-1:0] blink, logic [CFG_W-1:0] disp,
                             logic [CFG_W-1:0] thr);
        write_register(CFG_BLINK, blink);
        write_register(CFG_DISPLAY, disp);
        write_register(CFG_THRESHOLD, thr);
    endtask

    initial begin
        int          counted;
        int          pick;
        int          x;
        int          y;
        int          z;
        cmd_t        cmd;
        logic [47:0] data;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: short tick and display counts, default threshold.
        configure(2, 3, THRESHOLD_RESET);
        send(CMD_TICK, '0);                               // tick at rest
        send(CMD_BUTTON, '0);                             // button at rest is ignored
        send(CMD_SAMPLE, axes(-32768, 32767, -32768));    // sample at rest is ignored
        send(CMD_FALL, '0);                               // enter free fall at once
        send(CMD_SAMPLE, axes(0, 0, 0));                  // zero sum cannot arm an impact
        send(CMD_SAMPLE, axes(0, 0, 100));
        send(CMD_SAMPLE, axes(0, 0, 101));                // small change, no impact
        send(CMD_TICK, '0);
        send(CMD_TICK, '0);                               // blink toggles the LED
        send(CMD_FALL, '0);                               // latched while falling
        send(CMD_SAMPLE, axes(-32768, -32768, -32768));   // largest impact, digits wrap
        send(CMD_TICK, '0);
        send(CMD_TICK, '0);
        send(CMD_TICK, '0);                               // timeout, latched fall re-enters
        send(CMD_SAMPLE, axes(32767, 32767, 32767));
        send(CMD_SAMPLE, axes(1, 0, 0));
        send(CMD_BUTTON, '0);                             // button ends the display
        send(CMD_FALL, '0);
        drain();

        // Zero counts and zero threshold: once the blink count runs out every tick toggles, equal sums impact.
        configure(0, 0, 0);
        send(CMD_TICK, '0);
        send(CMD_TICK, '0);
        send(CMD_SAMPLE, axes(0, 0, 5));
        send(CMD_SAMPLE, axes(0, 0, 5));
        send(CMD_TICK, '0);
        drain();

        // Largest counts and threshold: no change can reach the threshold.
        configure(16'hFFFF, 16'hFFFF, THRESHOLD_MAX);
        send(CMD_FALL, '0);
        send(CMD_SAMPLE, axes(0, 0, 1));
        send(CMD_SAMPLE, axes(-32768, -32768, -32768));
        send(CMD_BUTTON, '0);
        drain();

        // Random segments, each with its own settings; the idle pattern changes every two segments.
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg)
                0: configure(1, 1, THRESHOLD_RESET);
                1: configure($urandom_range(1, 6), $urandom_range(1, 8),
                             $urandom_range(1000, 20000));
                2: configure(16'hFFFF, 16'hFFFF, THRESHOLD_RESET);
                3: configure($urandom_range(0, 4), $urandom_range(0, 4),
                             $urandom_range(0, 3000));
                4: configure(BLINK_RESET, DISPLAY_RESET, THRESHOLD_RESET);
                default: configure($urandom_range(1, 65535), $urandom_range(1, 20),
                                   $urandom_range(0, 40000));
            endcase
            if (seg < 2) begin
                send_idle_pct = 9;
                recv_idle_pct = 54;
            end else if (seg < 4) begin
                send_idle_pct = 54;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            counted = 0;
            while (counted < SEGMENT_ITEMS) begin
                pick = $urandom_range(0, 99);
                data = 48'({$urandom, $urandom});
                if (pick < 35) begin
                    cmd = CMD_TICK;
                end else if (pick < 75) begin
                    cmd  = CMD_SAMPLE;
                    pick = $urandom_range(0, 99);
                    if (pick < 55) begin
                        // Near one g on Z with a little noise.
                        x = $urandom_range(0, 40) - 20;
                        y = $urandom_range(0, 40) - 20;
                        z = $urandom_range(95, 105);
                        data = axes(x, y, z);
                    end else if (pick < 75) begin
                        // Hard hit on one axis.
                        x = $urandom_range(300, 3000);
                        if ($urandom_range(0, 1)) x = -x;
                        data = axes(x, $urandom_range(0, 200) - 100, 100);
                    end else if (pick < 80) begin
                        data = '0;
                    end
                end else if (pick < 85) begin
                    cmd = CMD_FALL;
                end else begin
                    cmd = CMD_BUTTON;
                end
                if ($urandom_range(0, 59) == 0) drain();
                send(cmd, data);
                counted++;
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.expected_q.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        end
        if (sb.errors == 0) begin
            $display("fall_impact_peak_detector_unit_test: done, clean");
        end else begin
            $display("fall_impact_peak_detector_unit_test: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/fipd_pkg.sv
rtl/fipd_isqrt.sv
rtl/fipd_bcd.sv
rtl/fall_impact_peak_detector_unit.sv
bench/fall_impact_peak_detector_unit_test.sv
